FILE: src/pbi_pkg.sv
// pbi_pkg: shared constants, types and the prime table for the prime bit interleaver
// no dependencies; imported by prime_bit_interleaver and pbi_chk
package pbi_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int PRIME_COUNT         = 69;
    localparam int PRIME_W             = 9;
    localparam int PIDX_W              = 7;
    localparam int CFG_LEN_W           = 7;
    localparam int FRAME_BYTES_RST     = 8;
    localparam int FIRST_PRIME         = 2;

    // register select, taken from paddr[2]
    localparam logic REG_FRAME_BYTES = 1'b0;
    localparam logic REG_DIRECTION   = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SEARCH,
        S_PERMUTE,
        S_DRAIN,
        S_EMIT
    } t_state;

    // ascending primes 2 .. 347
    function automatic logic [PRIME_W-1:0] prime_at(input logic [PIDX_W-1:0] idx);
        logic [PRIME_W-1:0] p;
        case (idx)
            7'd0:  p = 9'd2;    7'd1:  p = 9'd3;    7'd2:  p = 9'd5;    7'd3:  p = 9'd7;
            7'd4:  p = 9'd11;   7'd5:  p = 9'd13;   7'd6:  p = 9'd17;   7'd7:  p = 9'd19;
            7'd8:  p = 9'd23;   7'd9:  p = 9'd29;   7'd10: p = 9'd31;   7'd11: p = 9'd37;
            7'd12: p = 9'd41;   7'd13: p = 9'd43;   7'd14: p = 9'd47;   7'd15: p = 9'd53;
            7'd16: p = 9'd59;   7'd17: p = 9'd61;   7'd18: p = 9'd67;   7'd19: p = 9'd71;
            7'd20: p = 9'd73;   7'd21: p = 9'd79;   7'd22: p = 9'd83;   7'd23: p = 9'd89;
            7'd24: p = 9'd97;   7'd25: p = 9'd101;  7'd26: p = 9'd103;  7'd27: p = 9'd107;
            7'd28: p = 9'd109;  7'd29: p = 9'd113;  7'd30: p = 9'd127;  7'd31: p = 9'd131;
            7'd32: p = 9'd137;  7'd33: p = 9'd139;  7'd34: p = 9'd149;  7'd35: p = 9'd151;
            7'd36: p = 9'd157;  7'd37: p = 9'd163;  7'd38: p = 9'd167;  7'd39: p = 9'd173;
            7'd40: p = 9'd179;  7'd41: p = 9'd181;  7'd42: p = 9'd191;  7'd43: p = 9'd193;
            7'd44: p = 9'd197;  7'd45: p = 9'd199;  7'd46: p = 9'd211;  7'd47: p = 9'd223;
            7'd48: p = 9'd227;  7'd49: p = 9'd229;  7'd50: p = 9'd233;  7'd51: p = 9'd239;
            7'd52: p = 9'd241;  7'd53: p = 9'd251;  7'd54: p = 9'd257;  7'd55: p = 9'd263;
            7'd56: p = 9'd269;  7'd57: p = 9'd271;  7'd58: p = 9'd277;  7'd59: p = 9'd281;
            7'd60: p = 9'd283;  7'd61: p = 9'd293;  7'd62: p = 9'd307;  7'd63: p = 9'd311;
            7'd64: p = 9'd313;  7'd65: p = 9'd317;  7'd66: p = 9'd331;  7'd67: p = 9'd337;
            7'd68: p = 9'd347;
            default: p = 9'd347;
        endcase
        return p;
    endfunction

endpackage

FILE: src/prime_bit_interleaver.sv
// sequence: L load requests, then a prime table search, 8*L bit moves through the single
// bit-move datapath, one drain state and the emit of each byte after a registered store read
// (L = effective frame length in bytes); one frame at a time: input is stalled from frame
// close to last byte, and emit waits while the receiver stalls
// reset: synchronous active low; returns to loading with an empty frame, frame_bytes = 8,
// direction = 0; the byte stores are not cleared
module prime_bit_interleaver #(
    parameter int MAX_FRAME_BYTES = pbi_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    // output request channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);
    import pbi_pkg::*;

    // frame length, store address and bit position widths
    localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int PW = LW + 3;
    localparam int SW = ((PW > PRIME_W) ? PW : PRIME_W) + 1;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_FRAME_BYTES);

    // configuration registers
    logic [CFG_LEN_W-1:0] r_frame_bytes;
    logic                 r_dir;
    logic                 cfg_wr;

    // control
    t_state               r_state, n_state;
    logic [LW-1:0]        r_loaded;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        eff_len;
    logic [LW:0]          loaded_inc;
    logic                 in_acc, frame_close;

    // prime search
    logic [PIDX_W-1:0]    r_pidx;
    logic [PRIME_W-1:0]   r_prime;
    logic [PRIME_W-1:0]   p_cur;
    logic                 search_go, search_step;

    // bit mover
    logic [PW-1:0]        r_cnt, r_map;
    logic [PW-1:0]        nbits, src, dst, map_nx;
    logic [SW-1:0]        map_sum;
    logic                 perm_en, perm_last;

    // bit write pipeline stage
    logic                 r_p_valid;
    logic [2:0]           r_p_sel;
    logic [PW-1:0]        r_p_dst;
    logic [7:0]           r_fq;

    // emit
    logic [LW-1:0]        r_ek;
    logic                 r_rd_ok;
    logic [7:0]           r_rd;
    logic                 ek_last, out_free, out_load;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_last;

    // byte stores
    logic [7:0]           r_frame_mem [MAX_FRAME_BYTES];
    logic [7:0]           r_res_mem   [MAX_FRAME_BYTES];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= CFG_LEN_W'(FRAME_BYTES_RST);
            r_dir         <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FRAME_BYTES: r_frame_bytes <= pwdata[CFG_LEN_W-1:0];
                REG_DIRECTION:   r_dir         <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_BYTES: prdata = {{(32-CFG_LEN_W){1'b0}}, r_frame_bytes};
            REG_DIRECTION:   prdata = {31'd0, r_dir};
            default:         prdata = 32'd0;
        endcase
    end

    // zero acts as one byte, anything above the store depth saturates
    always_comb begin
        if (r_frame_bytes == '0) begin
            eff_len = LW'(1);
        end else if (r_frame_bytes > CFG_LEN_W'(MAX_FRAME_BYTES)) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = LW'(r_frame_bytes);
        end
    end

    // ---------------- datapath terms ----------------
    assign in_acc      = i_in_valid && !o_in_stall;
    assign loaded_inc  = {1'b0, r_loaded} + 1'b1;
    assign frame_close = loaded_inc >= {1'b0, eff_len};

    assign nbits       = {r_len, 3'b000};
    assign p_cur       = prime_at(r_pidx);
    // stop at the first table entry not below the bit count, or at the table end
    assign search_go   = (r_pidx < PIDX_W'(PRIME_COUNT)) && (SW'(p_cur) < SW'(nbits));

    // deinterleave swaps which side walks linearly
    assign src         = r_dir ? r_map : r_cnt;
    assign dst         = r_dir ? r_cnt : r_map;
    // the multiplier is always below the bit count, so one subtract keeps the address in range
    assign map_sum     = SW'(r_map) + SW'(r_prime);
    assign map_nx      = (map_sum >= SW'(nbits)) ? PW'(map_sum - SW'(nbits)) : PW'(map_sum);
    assign perm_last   = (r_cnt == nbits - 1'b1);

    assign ek_last     = (r_ek == r_len - 1'b1);
    assign out_free    = !r_out_valid || !i_out_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && frame_close) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (!search_go) n_state = S_PERMUTE;
            end
            S_PERMUTE: begin
                if (perm_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_load && ek_last) n_state = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != S_LOAD);
        search_step = (r_state == S_SEARCH) && search_go;
        perm_en     = (r_state == S_PERMUTE);
        out_load    = (r_state == S_EMIT) && r_rd_ok && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_loaded    <= '0;
            r_len       <= '0;
            r_pidx      <= '0;
            r_prime     <= '0;
            r_cnt       <= '0;
            r_map       <= '0;
            r_ek        <= '0;
            r_p_valid   <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= perm_en;
            // read data is marked good only after the read register has captured the current address
            r_rd_ok   <= (r_state == S_EMIT) && !out_load;

            if (in_acc) begin
                if (frame_close) begin
                    r_loaded <= '0;
                    r_len    <= eff_len;
                    r_pidx   <= PIDX_W'(1);
                    r_prime  <= PRIME_W'(FIRST_PRIME);
                end else begin
                    r_loaded <= LW'(loaded_inc);
                end
            end

            if (search_step) begin
                r_pidx  <= r_pidx + 1'b1;
                r_prime <= p_cur;
            end

            if ((r_state == S_SEARCH) && !search_go) begin
                r_cnt <= '0;
                r_map <= '0;
            end

            if (perm_en) begin
                r_cnt <= r_cnt + 1'b1;
                r_map <= map_nx;
            end

            if (r_state == S_DRAIN) begin
                r_ek <= '0;
            end

            if (out_load) begin
                r_ek        <= r_ek + 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_rd;
            r_last     <= ek_last;
        end
    end

    // ---------------- byte stores ----------------
    // frame store: written on each accepted input request, read by the bit mover
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_loaded < MAX_LEN)) begin
            r_frame_mem[r_loaded[AW-1:0]] <= i_in_byte;
        end
        r_fq <= r_frame_mem[src[AW+2:3]];
    end

    // bit stage registers, captured together with the frame read data
    always_ff @(posedge i_clk) begin
        r_p_sel <= src[2:0];
        r_p_dst <= dst;
    end

    // result store: bit-enable writes; the multiplier is coprime to the bit count,
    // so every result bit of the frame is written once and no clearing is needed
    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_res_mem[r_p_dst[AW+2:3]][r_p_dst[2:0]] <= r_fq[r_p_sel];
        end
        r_rd <= r_res_mem[r_ek[AW-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last;

endmodule

FILE: src/pbi_chk.sv
// pbi_chk: port-level checks for prime_bit_interleaver, bound to the top level
// depends on pbi_pkg and prime_bit_interleaver
module pbi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_last_byte
);
    import pbi_pkg::*;

    // reset leaves the block ready for a new frame with nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_last_byte)))
        else $error("stalled result request changed");

    // results only appear while input is held off
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while input was open");

    // until the final byte is out, no new input is taken
    a_mid_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_byte) |-> o_in_stall)
        else $error("input open before the frame was fully emitted");

endmodule

bind prime_bit_interleaver pbi_chk u_pbi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_last_byte (o_last_byte)
);

FILE: tb/prime_bit_interleaver_tb.sv
// prime_bit_interleaver_tb: self-checking bench for the prime bit interleaver
// checks every permuted byte against a local frame predictor; needs pbi_pkg and
// prime_bit_interleaver
`timescale 1ns / 100ps

module prime_bit_interleaver_tb;

    localparam int MAX_BYTES    = 64;
    localparam int SETTLE_CYC   = 16;      // quiet time before a register write
    localparam int TAIL_CYC     = 50;      // watch for strays after the last byte
    localparam int HOLD_CYC     = 300;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } perm_byte_t;

    // dut ports, all driven from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    // stimulus side
    logic [7:0]  byte_q[$];            // bytes waiting for the driver
    int unsigned bytes_issued = 0;     // requests put on the input bus
    int unsigned bytes_accepted = 0;   // requests taken by the block
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_req_cnt = 0;     // bumped to ask for a long hold-off
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // predictor state, mirrors the block's frame buffer and registers
    logic [6:0]  frame_bytes_cfg = 7'd8;
    logic        dir_cfg = 1'b0;
    logic [7:0]  frame_mem [MAX_BYTES];
    int unsigned loaded_count = 0;
    perm_byte_t  permuted_q[$];        // permuted bytes still owed by the block

    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    prime_bit_interleaver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // zero means one byte, anything past the buffer means a full buffer
    function automatic int unsigned eff_len(input logic [6:0] raw);
        int unsigned n;
        n = raw;
        if (n == 0) n = 1;
        if (n > MAX_BYTES) n = MAX_BYTES;
        return n;
    endfunction

    // load one byte; on frame close, permute and queue the whole output frame
    task automatic accept_frame_byte(input logic [7:0] b);
        int unsigned len, nbits, cand, d, mult, pos, n, src, dst;
        logic        is_prime;
        logic        bit_v;
        logic [7:0]  perm [MAX_BYTES];
        perm_byte_t  pb;
        len = eff_len(frame_bytes_cfg);
        if (loaded_count < MAX_BYTES) frame_mem[loaded_count] = b;
        loaded_count++;
        if (loaded_count < len) return;

        nbits = len * 8;
        // largest prime below the bit count, capped at the top of the table
        cand = (nbits > 348) ? 347 : nbits - 1;
        is_prime = 1'b0;
        while (!is_prime) begin
            is_prime = 1'b1;
            for (d = 2; d * d <= cand; d++) begin
                if (cand % d == 0) is_prime = 1'b0;
            end
            if (!is_prime) cand--;
        end
        mult = cand;

        foreach (perm[i]) perm[i] = 8'h00;
        pos = 0;
        for (n = 0; n < nbits; n++) begin
            // interleave scatters bit n, deinterleave gathers into bit n
            if (dir_cfg) begin
                src = pos;
                dst = n;
            end else begin
                src = n;
                dst = pos;
            end
            bit_v = frame_mem[src / 8][src % 8];
            perm[dst / 8][dst % 8] = perm[dst / 8][dst % 8] | bit_v;
            pos += mult;
            if (pos >= nbits) pos -= nbits;
        end
        for (n = 0; n < len; n++) begin
            pb.data = perm[n];
            pb.last = (n + 1 == len);
            permuted_q.push_back(pb);
        end
        loaded_count = 0;
    endtask

    // input driver: next request goes up once the current one is taken
    always @(negedge i_clk) begin: byte_driver
        if (!i_in_valid || bytes_accepted == bytes_issued) begin
            if (i_rst_n && byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid   <= 1'b1;
                i_in_byte    <= byte_q.pop_front();
                bytes_issued <= bytes_issued + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // input monitor: every accepted request feeds the predictor
    always @(posedge i_clk) begin: in_monitor
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            accept_frame_byte(i_in_byte);
            bytes_accepted <= bytes_accepted + 1;
        end
    end

    // receiver stall: a requested long hold-off wins over random stalls
    always @(negedge i_clk) begin: out_stall_driver
        if (hold_seen != hold_req_cnt) begin
            hold_seen   <= hold_req_cnt;
            hold_left   <= HOLD_CYC;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // output monitor: compare each accepted request with the oldest expected byte
    always @(posedge i_clk) begin: out_check
        perm_byte_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (permuted_q.size() == 0) begin
                $display("%0t: unexpected output byte %h last %b", $time, o_out_byte,
                         o_last_byte);
                err_count++;
            end else begin
                want = permuted_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.data,
                             o_out_byte);
                    err_count++;
                end
                if (o_last_byte !== want.last) begin
                    $display("%0t: last_byte expected %b actual %b", $time, want.last,
                             o_last_byte);
                    err_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin: watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
                     permuted_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // block idle: all queued bytes taken, nothing owed, then a quiet stretch
    task automatic wait_idle();
        while (byte_q.size() != 0 || bytes_accepted != bytes_issued
               || permuted_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // setup then access phase; written at the edge where pready is seen
    task automatic reg_write(input logic sel, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == pbi_pkg::REG_FRAME_BYTES) frame_bytes_cfg = data[6:0];
        else dir_cfg = data[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits of the write data are noise the block must ignore
    task automatic set_config(input logic [6:0] len_val, input logic dir_val);
        logic [31:0] noise;
        wait_idle();
        noise = $urandom;
        reg_write(pbi_pkg::REG_FRAME_BYTES, {noise[31:7], len_val});
        noise = $urandom;
        reg_write(pbi_pkg::REG_DIRECTION, {noise[31:1], dir_val});
    endtask

    task automatic push_bytes(input int unsigned cnt);
        repeat (cnt) byte_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // mostly short whole frames with random settings, sometimes a mid-frame shrink
    task automatic random_phase(input int unsigned budget);
        int unsigned sent, len_now, part, pick;
        logic [6:0]  len_val;
        sent = 0;
        while (sent < budget) begin
            len_now = eff_len(frame_bytes_cfg);
            if ($urandom_range(0, 9) == 0 && len_now > 1) begin
                // partial frame, then a length at or below what is loaded
                part = $urandom_range(1, (len_now - 1 > 12) ? 12 : len_now - 1);
                push_bytes(part);
                set_config(7'($urandom_range(0, part)), 1'($urandom_range(0, 1)));
                push_bytes(1);
                sent += part + 1;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) len_val = 7'd0;
                else if (pick < 3) len_val = 7'($urandom_range(9, 16));
                else len_val = 7'($urandom_range(1, 8));
                set_config(len_val, 1'($urandom_range(0, 1)));
                part = $urandom_range(1, 2) * eff_len(frame_bytes_cfg);
                push_bytes(part);
                sent += part;
            end
        end
    endtask

    initial begin: stimulus
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: 8-byte interleave, field extremes, single set bits at both ends and alternating patterns
        byte_q = {8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'hFF, 8'h00};
        // one-byte frame, deinterleave
        set_config(7'd1, 1'b1);
        byte_q.push_back(8'h96);
        // zero length behaves as one byte
        set_config(7'd0, 1'b0);
        byte_q.push_back(8'h3C);
        set_config(7'd2, 1'b1);
        byte_q.push_back(8'hC3);
        byte_q.push_back(8'h7E);
        // length lowered below what is already loaded: next byte closes the frame
        set_config(7'd8, 1'b1);
        push_bytes(5);
        set_config(7'd3, 1'b0);
        push_bytes(1);

        // no idling; receiver holds off so the block backs up into its input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(7'd6, 1'b0);
        hold_req_cnt++;
        push_bytes(12);
        // oversize length saturates to the full buffer and the top prime
        set_config(7'd127, 1'($urandom_range(0, 1)));
        push_bytes(MAX_BYTES);
        random_phase(4);

        // sender mostly idle
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        random_phase(4);

        // receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        random_phase(4);

        // both sides idle now and then
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        random_phase(4);

        wait_idle();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_count == 0 && permuted_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
src/pbi_pkg.sv
src/prime_bit_interleaver.sv
src/pbi_chk.sv
tb/prime_bit_interleaver_tb.sv
